// ----- hdl/fwss_pkg.sv -----
// shared types, widths and constants of the four wheel steer speed mixer
`timescale 1ns / 1ps
package fwss_pkg;

    localparam int TW = 31;
    localparam int AW = 33;
    localparam int NW = 59;
    localparam int DW = 44;
    localparam int QW = 29;
    localparam int SW = 33;

    localparam logic [TW-1:0] ONE_Q30 = TW'(32'h4000_0000);
    localparam logic signed [14:0] ANG_LIMIT = 15'sd8192;
    localparam logic signed [SW-1:0] OUT_MAX = SW'(131071);
    localparam logic signed [SW-1:0] OUT_MIN = -SW'(131072);

    localparam logic [1:0] REG_BASE_WIDTH = 2'd0;
    localparam logic [1:0] REG_WHEELBASE  = 2'd1;
    localparam logic [1:0] REG_STEER_GAIN = 2'd2;

    typedef struct packed {
        logic [15:0]   vm;
        logic [TW-1:0] x2;
        logic          v_neg;
        logic          th_neg;
        logic [30:0]   fp;
        logic          f_neg;
        logic [30:0]   bp;
        logic          b_neg;
    } fwss_side_t;

    function automatic logic signed [14:0] clamp_ang(input logic signed [14:0] a);
        logic signed [14:0] r;
        r = a;
        if (a > ANG_LIMIT)
        begin
            r = ANG_LIMIT;
        end
        else if (a < -ANG_LIMIT)
        begin
            r = -ANG_LIMIT;
        end
        return r;
    endfunction

endpackage

// ----- hdl/fwss_trig_cell.sv -----
// one taylor term of cos and sin, three register stages
`timescale 1ns / 1ps
module fwss_trig_cell
    import fwss_pkg::*;
#(
    parameter int K = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  fwss_side_t           in_side,
    input  logic [TW-1:0]        in_tc,
    input  logic [TW-1:0]        in_ts,
    input  logic signed [AW-1:0] in_ac,
    input  logic signed [AW-1:0] in_as,
    output logic                 out_valid,
    output fwss_side_t           out_side,
    output logic [TW-1:0]        out_tc,
    output logic [TW-1:0]        out_ts,
    output logic signed [AW-1:0] out_ac,
    output logic signed [AW-1:0] out_as
);

    localparam int unsigned DC = (2 * K - 1) * (2 * K);
    localparam int unsigned DS = (2 * K) * (2 * K + 1);
    localparam logic [31:0] RC = 32'(64'h1_0000_0000 / DC);
    localparam logic [31:0] RS = 32'(64'h1_0000_0000 / DS);

    logic                 v1_reg, v2_reg, v3_reg;
    fwss_side_t           side1_reg, side2_reg, side3_reg;
    logic [TW-1:0]        nc1_reg, ns1_reg, nc2_reg, ns2_reg;
    logic [TW-1:0]        qc2_reg, qs2_reg, tc3_reg, ts3_reg;
    logic signed [AW-1:0] ac1_reg, as1_reg, ac2_reg, as2_reg, ac3_reg, as3_reg;

    logic [61:0]   pc, ps;
    logic [62:0]   mc, ms;
    logic [TW-1:0] rem_c, rem_s, qc, qs;

    always_comb
    begin
        pc    = 62'(in_tc) * 62'(in_side.x2);
        ps    = 62'(in_ts) * 62'(in_side.x2);
        mc    = 63'(nc1_reg) * 63'(RC);
        ms    = 63'(ns1_reg) * 63'(RS);
        rem_c = nc2_reg - TW'(qc2_reg * TW'(DC));
        rem_s = ns2_reg - TW'(qs2_reg * TW'(DS));
        qc    = qc2_reg + TW'(rem_c >= TW'(DC));
        qs    = qs2_reg + TW'(rem_s >= TW'(DS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= in_side;
            nc1_reg   <= pc[60:30];
            ns1_reg   <= ps[60:30];
            ac1_reg   <= in_ac;
            as1_reg   <= in_as;

            side2_reg <= side1_reg;
            nc2_reg   <= nc1_reg;
            ns2_reg   <= ns1_reg;
            qc2_reg   <= mc[62:32];
            qs2_reg   <= ms[62:32];
            ac2_reg   <= ac1_reg;
            as2_reg   <= as1_reg;

            side3_reg <= side2_reg;
            tc3_reg   <= qc;
            ts3_reg   <= qs;
            if ((K % 2) == 1)
            begin
                ac3_reg <= ac2_reg - AW'(qc);
                as3_reg <= as2_reg - AW'(qs);
            end
            else
            begin
                ac3_reg <= ac2_reg + AW'(qc);
                as3_reg <= as2_reg + AW'(qs);
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;
    assign out_tc    = tc3_reg;
    assign out_ts    = ts3_reg;
    assign out_ac    = ac3_reg;
    assign out_as    = as3_reg;

endmodule

// ----- hdl/fwss_div_cell.sv -----
// one restoring division step for the common and differential quotients
`timescale 1ns / 1ps
module fwss_div_cell
    import fwss_pkg::*;
#(
    parameter int I = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  fwss_side_t    in_side,
    input  logic [NW-1:0] in_rc,
    input  logic [NW-1:0] in_ra,
    input  logic [DW-1:0] in_dc,
    input  logic [DW-1:0] in_da,
    input  logic [QW-1:0] in_qc,
    input  logic [QW-1:0] in_qa,
    output logic          out_valid,
    output fwss_side_t    out_side,
    output logic [NW-1:0] out_rc,
    output logic [NW-1:0] out_ra,
    output logic [DW-1:0] out_dc,
    output logic [DW-1:0] out_da,
    output logic [QW-1:0] out_qc,
    output logic [QW-1:0] out_qa
);

    localparam int CW = DW + QW;

    logic          v_reg;
    fwss_side_t    side_reg;
    logic [NW-1:0] rc_reg, ra_reg;
    logic [DW-1:0] dc_reg, da_reg;
    logic [QW-1:0] qc_reg, qa_reg;

    logic [CW-1:0] wrc, wra, wdc, wda;
    logic          take_c, take_a;

    always_comb
    begin
        wrc    = CW'(in_rc);
        wra    = CW'(in_ra);
        wdc    = CW'(in_dc) << I;
        wda    = CW'(in_da) << I;
        take_c = (wrc >= wdc);
        take_a = (wra >= wda);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            dc_reg   <= in_dc;
            da_reg   <= in_da;
            rc_reg   <= take_c ? NW'(wrc - wdc) : in_rc;
            ra_reg   <= take_a ? NW'(wra - wda) : in_ra;
            qc_reg   <= {in_qc[QW-2:0], take_c};
            qa_reg   <= {in_qa[QW-2:0], take_a};
        end
    end

    assign out_valid = v_reg;
    assign out_side  = side_reg;
    assign out_rc    = rc_reg;
    assign out_ra    = ra_reg;
    assign out_dc    = dc_reg;
    assign out_da    = da_reg;
    assign out_qc    = qc_reg;
    assign out_qa    = qa_reg;

endmodule

// ----- hdl/four_wheel_steer_speed_mixer.sv -----
// top level: four wheel steer speed mixer pipeline
// the pipeline is 6 taylor cells of 3 stages, 29 divider cells and 6 single stages
// throughput: one item per cycle while no result item waits, every stage takes a new item each enabled cycle
// the whole pipeline holds while a result item waits on m_tready
// reset: pipeline emptied, base width 1000, wheelbase 1000, steer gain 256
`timescale 1ns / 1ps
module four_wheel_steer_speed_mixer
    import fwss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // cmd_speed, cmd_angle, front_angle, back_angle, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // front_left, front_right, back_left, back_right speed
    output logic        m_tuser,  // saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [12:0] base_width_reg, wheelbase_reg;
    logic [15:0] steer_gain_reg;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_width_reg <= 13'd1000;
            wheelbase_reg  <= 13'd1000;
            steer_gain_reg <= 16'd256;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_BASE_WIDTH: base_width_reg <= pwdata[12:0];
                REG_WHEELBASE:  wheelbase_reg  <= pwdata[12:0];
                REG_STEER_GAIN: steer_gain_reg <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BASE_WIDTH: prdata = 32'(base_width_reg);
            REG_WHEELBASE:  prdata = 32'(wheelbase_reg);
            REG_STEER_GAIN: prdata = 32'(steer_gain_reg);
            default:        prdata = 32'd0;
        endcase
    end

    logic en;
    logic m_valid_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // stage a: clamp angles, form errors
    logic               a_valid_reg;
    logic signed [15:0] a_v_reg, a_fe_reg, a_be_reg;
    logic signed [14:0] a_th_reg;
    logic signed [14:0] th_cl, fa_cl, ba_cl;

    always_comb
    begin
        th_cl = clamp_ang(s_tdata[30:16]);
        fa_cl = clamp_ang(s_tdata[45:31]);
        ba_cl = clamp_ang(s_tdata[60:46]);
    end

    // stage b: magnitudes, x squared, correction products
    logic          b_valid_reg;
    fwss_side_t    b_side_reg;
    logic [TW-1:0] b_x_reg;
    logic [15:0]   vmag, femag, bemag;
    logic [14:0]   thn;
    logic [27:0]   sq;

    always_comb
    begin
        vmag  = a_v_reg[15] ? 16'(-a_v_reg) : 16'(a_v_reg);
        thn   = a_th_reg[14] ? 15'(-a_th_reg) : 15'(a_th_reg);
        femag = a_fe_reg[15] ? 16'(-a_fe_reg) : 16'(a_fe_reg);
        bemag = a_be_reg[15] ? 16'(-a_be_reg) : 16'(a_be_reg);
        sq    = 28'(thn[13:0]) * 28'(thn[13:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_v_reg  <= s_tdata[15:0];
            a_th_reg <= th_cl;
            a_fe_reg <= 16'(fa_cl) - 16'(th_cl);
            a_be_reg <= 16'(th_cl) + 16'(ba_cl);

            b_side_reg.vm     <= vmag;
            b_side_reg.x2     <= {sq[26:0], 4'b0000};
            b_side_reg.v_neg  <= a_v_reg[15];
            b_side_reg.th_neg <= a_th_reg[14];
            b_side_reg.fp     <= 31'(femag[14:0]) * 31'(steer_gain_reg);
            b_side_reg.f_neg  <= a_fe_reg[15];
            b_side_reg.bp     <= 31'(bemag[14:0]) * 31'(steer_gain_reg);
            b_side_reg.b_neg  <= a_be_reg[15];
            b_x_reg           <= {thn[13:0], 17'd0};
        end
    end

    // taylor chain
    logic                 t_v    [0:6];
    fwss_side_t           t_side [0:6];
    logic [TW-1:0]        t_tc   [0:6];
    logic [TW-1:0]        t_ts   [0:6];
    logic signed [AW-1:0] t_ac   [0:6];
    logic signed [AW-1:0] t_as   [0:6];

    assign t_v[0]    = b_valid_reg;
    assign t_side[0] = b_side_reg;
    assign t_tc[0]   = ONE_Q30;
    assign t_ts[0]   = b_x_reg;
    assign t_ac[0]   = AW'(ONE_Q30);
    assign t_as[0]   = AW'(b_x_reg);

    for (genvar gi = 0; gi < 6; gi++)
    begin : g_trig
        fwss_trig_cell #(
            .K (gi + 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (t_v[gi]),
            .in_side   (t_side[gi]),
            .in_tc     (t_tc[gi]),
            .in_ts     (t_ts[gi]),
            .in_ac     (t_ac[gi]),
            .in_as     (t_as[gi]),
            .out_valid (t_v[gi+1]),
            .out_side  (t_side[gi+1]),
            .out_tc    (t_tc[gi+1]),
            .out_ts    (t_ts[gi+1]),
            .out_ac    (t_ac[gi+1]),
            .out_as    (t_as[gi+1])
        );
    end

    // stage c: clamp cos and sin, first products
    logic          c_valid_reg;
    fwss_side_t    c_side_reg;
    logic [46:0]   c_p1_reg;
    logic [DW-1:0] c_da_reg, c_dc_reg;
    logic [NW-1:0] c_nc_reg;
    logic [TW-1:0] cosv, sinv;
    logic [12:0]   len;

    always_comb
    begin
        cosv = (t_ac[6] < AW'(1)) ? TW'(1) : t_ac[6][TW-1:0];
        sinv = t_as[6][AW-1] ? TW'(0) : t_as[6][TW-1:0];
        len  = (wheelbase_reg == 13'd0) ? 13'd1 : wheelbase_reg;
    end

    // stage d: numerator product, stage e: rounding offsets
    logic          d_valid_reg, e_valid_reg;
    fwss_side_t    d_side_reg, e_side_reg;
    logic [NW-1:0] d_na_reg, d_nc_reg, e_na_reg, e_nc_reg;
    logic [DW-1:0] d_da_reg, d_dc_reg, e_da_reg, e_dc_reg;
    logic [59:0]   pna;

    assign pna = 60'(c_p1_reg) * 60'(base_width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= t_v[6];
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg <= t_side[6];
            c_p1_reg   <= 47'(t_side[6].vm) * 47'(sinv);
            c_da_reg   <= DW'(cosv) * DW'(len);
            c_dc_reg   <= DW'(cosv);
            c_nc_reg   <= (NW'(t_side[6].vm) << 30) + NW'(cosv >> 1);

            d_side_reg <= c_side_reg;
            d_na_reg   <= NW'(pna);
            d_nc_reg   <= c_nc_reg;
            d_da_reg   <= c_da_reg;
            d_dc_reg   <= c_dc_reg;

            e_side_reg <= d_side_reg;
            e_na_reg   <= d_na_reg + NW'(d_da_reg >> 1);
            e_nc_reg   <= d_nc_reg;
            e_da_reg   <= d_da_reg;
            e_dc_reg   <= d_dc_reg;
        end
    end

    // divider chain
    logic          q_v    [0:QW];
    fwss_side_t    q_side [0:QW];
    logic [NW-1:0] q_rc   [0:QW];
    logic [NW-1:0] q_ra   [0:QW];
    logic [DW-1:0] q_dc   [0:QW];
    logic [DW-1:0] q_da   [0:QW];
    logic [QW-1:0] q_qc   [0:QW];
    logic [QW-1:0] q_qa   [0:QW];

    assign q_v[0]    = e_valid_reg;
    assign q_side[0] = e_side_reg;
    assign q_rc[0]   = e_nc_reg;
    assign q_ra[0]   = e_na_reg;
    assign q_dc[0]   = e_dc_reg;
    assign q_da[0]   = e_da_reg;
    assign q_qc[0]   = '0;
    assign q_qa[0]   = '0;

    for (genvar gj = 0; gj < QW; gj++)
    begin : g_div
        fwss_div_cell #(
            .I (QW - 1 - gj)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (q_v[gj]),
            .in_side   (q_side[gj]),
            .in_rc     (q_rc[gj]),
            .in_ra     (q_ra[gj]),
            .in_dc     (q_dc[gj]),
            .in_da     (q_da[gj]),
            .in_qc     (q_qc[gj]),
            .in_qa     (q_qa[gj]),
            .out_valid (q_v[gj+1]),
            .out_side  (q_side[gj+1]),
            .out_rc    (q_rc[gj+1]),
            .out_ra    (q_ra[gj+1]),
            .out_dc    (q_dc[gj+1]),
            .out_da    (q_da[gj+1]),
            .out_qc    (q_qc[gj+1]),
            .out_qa    (q_qa[gj+1])
        );
    end

    // mix and saturate
    fwss_side_t           fs;
    logic signed [SW-1:0] com, adj, fcor, bcor;
    logic signed [SW-1:0] sfl, sfr, sbl, sbr;
    logic [30:0]          frnd, brnd;
    logic [17:0]          ofl, ofr, obl, obr;
    logic                 sat;

    always_comb
    begin
        fs   = q_side[QW];
        frnd = (fs.fp + 31'd256) >> 9;
        brnd = (fs.bp + 31'd256) >> 9;
        com  = fs.v_neg ? -SW'(q_qc[QW]) : SW'(q_qc[QW]);
        adj  = (fs.v_neg != fs.th_neg) ? -SW'(q_qa[QW]) : SW'(q_qa[QW]);
        fcor = fs.f_neg ? -SW'(frnd) : SW'(frnd);
        bcor = fs.b_neg ? -SW'(brnd) : SW'(brnd);
        sfl  = com - adj + fcor;
        sfr  = com + adj - fcor;
        sbl  = com - adj + bcor;
        sbr  = com + adj - bcor;
        sat  = 1'b0;
        ofl  = sfl[17:0];
        ofr  = sfr[17:0];
        obl  = sbl[17:0];
        obr  = sbr[17:0];
        if (sfl > OUT_MAX) begin ofl = OUT_MAX[17:0]; sat = 1'b1; end
        if (sfl < OUT_MIN) begin ofl = OUT_MIN[17:0]; sat = 1'b1; end
        if (sfr > OUT_MAX) begin ofr = OUT_MAX[17:0]; sat = 1'b1; end
        if (sfr < OUT_MIN) begin ofr = OUT_MIN[17:0]; sat = 1'b1; end
        if (sbl > OUT_MAX) begin obl = OUT_MAX[17:0]; sat = 1'b1; end
        if (sbl < OUT_MIN) begin obl = OUT_MIN[17:0]; sat = 1'b1; end
        if (sbr > OUT_MAX) begin obr = OUT_MAX[17:0]; sat = 1'b1; end
        if (sbr < OUT_MIN) begin obr = OUT_MIN[17:0]; sat = 1'b1; end
    end

    logic [71:0] m_data_reg;
    logic        m_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= q_v[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg <= {obr, obl, ofr, ofl};
            m_user_reg <= sat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- test/tb_four_wheel_steer_speed_mixer.sv -----
// testbench of the four wheel steer speed mixer: directed and random commands checked by a predictor
`timescale 1ns / 1ps
module tb_four_wheel_steer_speed_mixer;
    import fwss_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [17:0] fl;
        logic [17:0] fr;
        logic [17:0] bl;
        logic [17:0] br;
        logic        sat;
    } wheel_speeds_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    wheel_speeds_t pending_speeds[$];
    longint unsigned track_mm, axle_mm, gain_q8;
    int gap_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int sent_items = 0;
    int checked_items = 0;
    int sat_items = 0;
    int quiet_cycles = 0;
    bit sent_now;

    four_wheel_steer_speed_mixer i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic longint clamp_rad(input logic [14:0] a);
        longint r;
        r = longint'($signed(a));
        if (r > 8192)
        begin
            r = 8192;
        end
        else if (r < -8192)
        begin
            r = -8192;
        end
        return r;
    endfunction

    function automatic longint unsigned round_div(input longint unsigned n,
                                                  input longint unsigned d);
        return (n + d / 2) / d;
    endfunction

    function automatic longint steer_fix(input longint err);
        longint unsigned m;
        longint r;
        m = err < 0 ? longint'(-err) : longint'(err);
        r = longint'(round_div(m * gain_q8, 512));
        return err < 0 ? -r : r;
    endfunction

    function automatic logic [17:0] clip18(input longint v, inout logic flag);
        if (v > 131071)
        begin
            v = 131071;
            flag = 1'b1;
        end
        if (v < -131072)
        begin
            v = -131072;
            flag = 1'b1;
        end
        return v[17:0];
    endfunction

    function automatic wheel_speeds_t mix_speeds(input logic [15:0] v_raw,
                                                 input logic [14:0] th_raw,
                                                 input logic [14:0] fa_raw,
                                                 input logic [14:0] ba_raw);
        longint v, th, fa, ba, cosv, sinv, common, adj, fc, bc;
        longint unsigned vm, thm, x, x2, t, len;
        wheel_speeds_t r;
        logic flag;
        v = longint'($signed(v_raw));
        th = clamp_rad(th_raw);
        fa = clamp_rad(fa_raw);
        ba = clamp_rad(ba_raw);
        vm = v < 0 ? -v : v;
        thm = th < 0 ? -th : th;
        x = thm << 17;
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        cosv = longint'(t);
        for (int k = 1; k <= 6; k++)
        begin
            t = ((t * x2) >> 30) / ((2 * k - 1) * (2 * k));
            cosv = (k % 2) ? cosv - longint'(t) : cosv + longint'(t);
        end
        t = x;
        sinv = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            t = ((t * x2) >> 30) / ((2 * k) * (2 * k + 1));
            sinv = (k % 2) ? sinv - longint'(t) : sinv + longint'(t);
        end
        if (cosv < 1)
        begin
            cosv = 1;
        end
        if (sinv < 0)
        begin
            sinv = 0;
        end
        len = axle_mm != 0 ? axle_mm : 1;
        common = longint'(round_div(vm << 30, cosv));
        if (v < 0)
        begin
            common = -common;
        end
        adj = longint'(round_div(vm * sinv * track_mm, cosv * len));
        if ((v < 0) != (th < 0))
        begin
            adj = -adj;
        end
        fc = steer_fix(fa - th);
        bc = steer_fix(th + ba);
        flag = 1'b0;
        r.fl = clip18(common - adj + fc, flag);
        r.fr = clip18(common + adj - fc, flag);
        r.bl = clip18(common - adj + bc, flag);
        r.br = clip18(common + adj - bc, flag);
        r.sat = flag;
        return r;
    endfunction

    // one item per call, valid kept high across back to back items
    task automatic send_command(input logic [15:0] v, input logic [14:0] th,
                                input logic [14:0] fa, input logic [14:0] ba);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, ba, fa, th, v};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_speeds.push_back(mix_speeds(v, th, fa, ba));
        sent_items++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_speeds.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BASE_WIDTH: track_mm = value[12:0];
            REG_WHEELBASE:  axle_mm = value[12:0];
            REG_STEER_GAIN: gain_q8 = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [31:0] b, input logic [31:0] l,
                                input logic [31:0] g);
        wait_drained();
        write_reg(REG_BASE_WIDTH, b);
        write_reg(REG_WHEELBASE, l);
        write_reg(REG_STEER_GAIN, g);
    endtask

    function automatic logic [14:0] pick_angle();
        if ($urandom_range(99) < 15)
        begin
            return 15'($urandom);
        end
        return 15'($urandom_range(16384) - 8192);
    endfunction

    task automatic test_extremes();
        logic [14:0] angs[8];
        angs = '{15'h4000, 15'h3FFF, 15'h2000, 15'h2001, -15'sd8192, -15'sd8193, 15'h0000,
                 15'h7FFF};
        send_command(16'h0000, 15'h0000, 15'h0000, 15'h0000);
        send_command(16'h7FFF, 15'h0000, 15'h0000, 15'h0000);
        send_command(16'h8000, 15'h0000, 15'h0000, 15'h0000);
        foreach (angs[i])
        begin
            send_command(i % 2 ? 16'h7FFF : 16'h8000, angs[i], angs[7 - i], angs[i]);
        end
        // pause until the pipeline has emptied
        wait_drained();
        foreach (angs[i])
        begin
            send_command(16'($urandom), angs[i], angs[(i + 3) % 8], angs[(i + 5) % 8]);
        end
        send_command(16'h1000, 15'h2000, -15'sd8192, 15'h2000);
        send_command(16'hF000, -15'sd8192, 15'h2000, -15'sd8192);
    endtask

    task automatic test_register_corners();
        // zero wheelbase acts as one, zero width and gain give no terms
        set_geometry(0, 0, 0);
        test_extremes();
        set_geometry(8191, 1, 65535);
        test_extremes();
        wait_drained();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        write_reg(REG_BASE_WIDTH, 32'hFFFF_E001);
        test_extremes();
    endtask

    task automatic test_random_mix();
        int modes[4][2];
        logic [31:0] geo[5][3];
        modes = '{'{0, 0}, '{61, 0}, '{0, 61}, '{16, 16}};
        geo = '{'{1000, 1000, 256}, '{1, 8191, 65535}, '{8191, 1, 0},
                '{$urandom_range(8191), $urandom_range(8191), $urandom_range(65535)},
                '{$urandom_range(2000), $urandom_range(4000, 8191), $urandom_range(1024)}};
        foreach (geo[g])
        begin
            set_geometry(geo[g][0], geo[g][1], geo[g][2]);
            foreach (modes[m])
            begin
                gap_pct = modes[m][0];
                stall_pct = modes[m][1];
                repeat (90)
                begin
                    send_command(16'($urandom), pick_angle(), pick_angle(), pick_angle());
                end
            end
        end
        gap_pct = 0;
        stall_pct = 0;
    endtask

    always @(posedge clk)
    begin
        wheel_speeds_t want;
        wheel_speeds_t got;
        m_tready <= ($urandom_range(99) >= stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[17:0], m_tdata[35:18], m_tdata[53:36], m_tdata[71:54], m_tuser};
            checked_items++;
            if (pending_speeds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected item %h", got);
                end
            end
            else
            begin
                want = pending_speeds.pop_front();
                if (want.sat)
                begin
                    sat_items++;
                end
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("item %0d: expected fl %h fr %h bl %h br %h sat %b",
                                 checked_items, want.fl, want.fr, want.bl, want.br, want.sat);
                        $display("          actual   fl %h fr %h bl %h br %h sat %b",
                                 got.fl, got.fr, got.bl, got.br, got.sat);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        sent_now = (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel;
        quiet_cycles = sent_now ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout with %0d items pending", pending_speeds.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        track_mm = 1000;
        axle_mm = 1000;
        gain_q8 = 256;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_register_corners();
        test_random_mix();
        wait_drained();
        $display("sent %0d commands, checked %0d wheel speed items, %0d saturated",
                 sent_items, checked_items, sat_items);
        $display("covered register corners, angle clamping and four idle patterns");
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
